FILE: rtl/fcc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fcc_pkg;

    localparam int RULE_SLOTS  = 32;
    localparam int FACT_SLOTS  = 32;
    localparam int SYMBOL_BITS = 8;

    localparam int RULE_IDX_BITS = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
    localparam int RULE_CNT_BITS = $clog2(RULE_SLOTS + 1);
    localparam int FACT_IDX_BITS = (FACT_SLOTS > 1) ? $clog2(FACT_SLOTS) : 1;
    localparam int FACT_CNT_BITS = $clog2(FACT_SLOTS + 1);

    typedef logic [SYMBOL_BITS-1:0] symbol_t;

    typedef enum logic [1:0] {
        FUNC_ADD_RULE = 2'd0,
        FUNC_ADD_FACT = 2'd1,
        FUNC_RUN      = 2'd2,
        FUNC_CLEAR    = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        KIND_ACCEPTED = 2'd0,
        KIND_IGNORED  = 2'd1,
        KIND_DERIVED  = 2'd2,
        KIND_DONE     = 2'd3
    } kind_t;

endpackage

`default_nettype wire

FILE: rtl/forward_chaining_closure_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                   Payload
// item      item_valid / item_ready     func, symbol_a, symbol_b
// result    result_valid / result_ready kind, symbol, saturated, last
//
// Add rule and clear facts go straight to the result; add fact first searches the fact list.
// A run visits rules one at a time: it fetches a rule, then searches the facts for the premise
// and then the conclusion, all through the single fact memory read port.
// A search ends at the first match or when it reaches the end of the list.
// Passes repeat until one derives nothing or the fact list is full.
// item_ready is high only while the sequencer is idle; a result waits in the output register.
// Reset empties the rule table and fact list at once; no clearing pass is needed.

module forward_chaining_closure_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         item_valid,
    output logic                              item_ready,
    input  wire logic [1:0]                   func,
    input  wire logic [fcc_pkg::SYMBOL_BITS-1:0] symbol_a,
    input  wire logic [fcc_pkg::SYMBOL_BITS-1:0] symbol_b,
    output logic                              result_valid,
    input  wire logic                         result_ready,
    output logic [1:0]                        kind,
    output logic [fcc_pkg::SYMBOL_BITS-1:0]   symbol,
    output logic                              saturated,
    output logic                              last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_RULE_RD,
        S_RULE_KEY,
        S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        PH_FACT,
        PH_PREM,
        PH_CONC
    } phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;

    logic [fcc_pkg::RULE_CNT_BITS-1:0] rule_total_reg, rule_total_next;
    logic [fcc_pkg::FACT_CNT_BITS-1:0] fact_total_reg, fact_total_next;
    logic [fcc_pkg::RULE_CNT_BITS-1:0] rule_idx_reg, rule_idx_next;
    logic [fcc_pkg::FACT_CNT_BITS-1:0] scan_idx_reg, scan_idx_next;
    fcc_pkg::symbol_t key_reg, key_next;
    logic added_reg, added_next;

    fcc_pkg::kind_t pend_kind_reg, pend_kind_next;
    fcc_pkg::symbol_t pend_sym_reg, pend_sym_next;
    logic pend_sat_reg, pend_sat_next;
    logic pend_last_reg, pend_last_next;

    logic out_valid_reg, out_valid_next;
    fcc_pkg::kind_t out_kind_reg, out_kind_next;
    fcc_pkg::symbol_t out_sym_reg, out_sym_next;
    logic out_sat_reg, out_sat_next;
    logic out_last_reg, out_last_next;

    // Memories for the rule table and fact list.
    fcc_pkg::symbol_t rule_prem_mem [fcc_pkg::RULE_SLOTS];
    fcc_pkg::symbol_t rule_conc_mem [fcc_pkg::RULE_SLOTS];
    fcc_pkg::symbol_t fact_mem      [fcc_pkg::FACT_SLOTS];
    fcc_pkg::symbol_t prem_rd_reg;
    fcc_pkg::symbol_t conc_rd_reg;
    fcc_pkg::symbol_t fact_rd_reg;

    logic rule_we, rule_re, fact_we, fact_re;

    logic item_fire;
    logic out_free;
    logic fact_full;
    logic scan_done;
    logic scan_found;

    assign item_ready = (state_reg == S_IDLE);
    assign item_fire  = item_valid && item_ready;
    assign out_free   = !out_valid_reg || result_ready;
    assign fact_full  = (fact_total_reg == fcc_pkg::FACT_CNT_BITS'(fcc_pkg::FACT_SLOTS));

    assign result_valid = out_valid_reg;
    assign kind         = out_kind_reg;
    assign symbol       = out_sym_reg;
    assign saturated    = out_sat_reg;
    assign last         = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (rule_we)
        begin
            rule_prem_mem[rule_total_reg[fcc_pkg::RULE_IDX_BITS-1:0]] <= symbol_a;
            rule_conc_mem[rule_total_reg[fcc_pkg::RULE_IDX_BITS-1:0]] <= symbol_b;
        end
        if (rule_re)
        begin
            prem_rd_reg <= rule_prem_mem[rule_idx_reg[fcc_pkg::RULE_IDX_BITS-1:0]];
            conc_rd_reg <= rule_conc_mem[rule_idx_reg[fcc_pkg::RULE_IDX_BITS-1:0]];
        end
        if (fact_we)
        begin
            fact_mem[fact_total_reg[fcc_pkg::FACT_IDX_BITS-1:0]] <= key_reg;
        end
        if (fact_re)
        begin
            fact_rd_reg <= fact_mem[scan_idx_reg[fcc_pkg::FACT_IDX_BITS-1:0]];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        rule_total_next = rule_total_reg;
        fact_total_next = fact_total_reg;
        rule_idx_next   = rule_idx_reg;
        scan_idx_next   = scan_idx_reg;
        key_next        = key_reg;
        added_next      = added_reg;
        pend_kind_next  = pend_kind_reg;
        pend_sym_next   = pend_sym_reg;
        pend_sat_next   = pend_sat_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_sym_next    = out_sym_reg;
        out_sat_next    = out_sat_reg;
        out_last_next   = out_last_reg;
        rule_we         = 1'b0;
        rule_re         = 1'b0;
        fact_we         = 1'b0;
        fact_re         = 1'b0;
        scan_done       = 1'b0;
        scan_found      = 1'b0;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_fire)
                begin
                    pend_sym_next  = '0;
                    pend_sat_next  = 1'b0;
                    pend_last_next = 1'b1;
                    case (fcc_pkg::func_t'(func))
                        fcc_pkg::FUNC_ADD_RULE:
                        begin
                            if (rule_total_reg < fcc_pkg::RULE_CNT_BITS'(fcc_pkg::RULE_SLOTS))
                            begin
                                rule_we         = 1'b1;
                                rule_total_next = rule_total_reg
                                                  + fcc_pkg::RULE_CNT_BITS'(1);
                                pend_kind_next  = fcc_pkg::KIND_ACCEPTED;
                            end
                            else
                            begin
                                pend_kind_next = fcc_pkg::KIND_IGNORED;
                            end
                            state_next = S_EMIT;
                        end
                        fcc_pkg::FUNC_ADD_FACT:
                        begin
                            key_next      = symbol_a;
                            phase_next    = PH_FACT;
                            scan_idx_next = '0;
                            state_next    = S_SCAN_RD;
                        end
                        fcc_pkg::FUNC_RUN:
                        begin
                            rule_idx_next = '0;
                            added_next    = 1'b0;
                            state_next    = S_RULE_RD;
                        end
                        fcc_pkg::FUNC_CLEAR:
                        begin
                            fact_total_next = '0;
                            pend_kind_next  = fcc_pkg::KIND_ACCEPTED;
                            state_next      = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                if (scan_idx_reg == fact_total_reg)
                begin
                    scan_done = 1'b1;
                end
                else
                begin
                    fact_re    = 1'b1;
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (fact_rd_reg == key_reg)
                begin
                    scan_done  = 1'b1;
                    scan_found = 1'b1;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + fcc_pkg::FACT_CNT_BITS'(1);
                    state_next    = S_SCAN_RD;
                end
            end

            S_RULE_RD:
            begin
                if (rule_idx_reg == rule_total_reg)
                begin
                    // End of a pass: sweep again only if something was derived.
                    if (added_reg)
                    begin
                        rule_idx_next = '0;
                        added_next    = 1'b0;
                    end
                    else
                    begin
                        pend_kind_next = fcc_pkg::KIND_DONE;
                        pend_sym_next  = '0;
                        pend_sat_next  = 1'b0;
                        pend_last_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                end
                else
                begin
                    rule_re    = 1'b1;
                    state_next = S_RULE_KEY;
                end
            end

            S_RULE_KEY:
            begin
                key_next      = prem_rd_reg;
                phase_next    = PH_PREM;
                scan_idx_next = '0;
                state_next    = S_SCAN_RD;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = pend_kind_reg;
                    out_sym_next   = pend_sym_reg;
                    out_sat_next   = pend_sat_reg;
                    out_last_next  = pend_last_reg;
                    if (pend_last_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rule_idx_next = rule_idx_reg + fcc_pkg::RULE_CNT_BITS'(1);
                        state_next    = S_RULE_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished fact search is resolved according to what asked for it.
        if (scan_done)
        begin
            case (phase_reg)
                PH_FACT:
                begin
                    pend_sym_next  = '0;
                    pend_last_next = 1'b1;
                    pend_kind_next = fcc_pkg::KIND_IGNORED;
                    pend_sat_next  = 1'b0;
                    if (!scan_found)
                    begin
                        if (fact_full)
                        begin
                            pend_sat_next = 1'b1;
                        end
                        else
                        begin
                            fact_we         = 1'b1;
                            fact_total_next = fact_total_reg + fcc_pkg::FACT_CNT_BITS'(1);
                            pend_kind_next  = fcc_pkg::KIND_ACCEPTED;
                        end
                    end
                    state_next = S_EMIT;
                end
                PH_PREM:
                begin
                    if (scan_found)
                    begin
                        key_next      = conc_rd_reg;
                        phase_next    = PH_CONC;
                        scan_idx_next = '0;
                        state_next    = S_SCAN_RD;
                    end
                    else
                    begin
                        rule_idx_next = rule_idx_reg + fcc_pkg::RULE_CNT_BITS'(1);
                        state_next    = S_RULE_RD;
                    end
                end
                PH_CONC:
                begin
                    if (scan_found)
                    begin
                        rule_idx_next = rule_idx_reg + fcc_pkg::RULE_CNT_BITS'(1);
                        state_next    = S_RULE_RD;
                    end
                    else if (fact_full)
                    begin
                        pend_kind_next = fcc_pkg::KIND_DONE;
                        pend_sym_next  = '0;
                        pend_sat_next  = 1'b1;
                        pend_last_next = 1'b1;
                        state_next     = S_EMIT;
                    end
                    else
                    begin
                        fact_we         = 1'b1;
                        fact_total_next = fact_total_reg + fcc_pkg::FACT_CNT_BITS'(1);
                        added_next      = 1'b1;
                        pend_kind_next  = fcc_pkg::KIND_DERIVED;
                        pend_sym_next   = key_reg;
                        pend_sat_next   = 1'b0;
                        pend_last_next  = 1'b0;
                        state_next      = S_EMIT;
                    end
                end
                default:
                begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_FACT;
            rule_total_reg <= '0;
            fact_total_reg <= '0;
            rule_idx_reg   <= '0;
            scan_idx_reg   <= '0;
            key_reg        <= '0;
            added_reg      <= 1'b0;
            pend_kind_reg  <= fcc_pkg::KIND_ACCEPTED;
            pend_sym_reg   <= '0;
            pend_sat_reg   <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= fcc_pkg::KIND_ACCEPTED;
            out_sym_reg    <= '0;
            out_sat_reg    <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            rule_total_reg <= rule_total_next;
            fact_total_reg <= fact_total_next;
            rule_idx_reg   <= rule_idx_next;
            scan_idx_reg   <= scan_idx_next;
            key_reg        <= key_next;
            added_reg      <= added_next;
            pend_kind_reg  <= pend_kind_next;
            pend_sym_reg   <= pend_sym_next;
            pend_sat_reg   <= pend_sat_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_sym_reg    <= out_sym_next;
            out_sat_reg    <= out_sat_next;
            out_last_reg   <= out_last_next;
        end
    end

    a_fact_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fact_total_reg <= fcc_pkg::FACT_CNT_BITS'(fcc_pkg::FACT_SLOTS))
        else $error("fact count exceeds the list size");

    a_rule_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rule_total_reg <= fcc_pkg::RULE_CNT_BITS'(fcc_pkg::RULE_SLOTS))
        else $error("rule count exceeds the table size");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |=> !item_ready)
        else $error("block accepted a transaction while still busy");

    a_derived_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_kind_reg == fcc_pkg::KIND_DERIVED) |-> (!last && !saturated))
        else $error("derived result marked last or saturated");

    a_symbol_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && out_kind_reg != fcc_pkg::KIND_DERIVED) |-> (symbol == '0))
        else $error("non-derived result carries a symbol");

endmodule

`default_nettype wire

FILE: tb/forward_chaining_closure_unit_test.sv
`timescale 1ns / 1ps

module forward_chaining_closure_unit_test;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int ITEM_TARGET = 110;
    localparam int FILL_ROOM = 40;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        fcc_pkg::kind_t   kind;
        fcc_pkg::symbol_t symbol;
        logic             saturated;
        logic             last;
    } outcome_t;

    // Mirrors the rule table and fact list and queues the outcomes each transaction causes.
    class closure_scoreboard;
        fcc_pkg::symbol_t rule_premise [fcc_pkg::RULE_SLOTS];
        fcc_pkg::symbol_t rule_conclusion [fcc_pkg::RULE_SLOTS];
        int               rule_count;
        fcc_pkg::symbol_t fact_list [fcc_pkg::FACT_SLOTS];
        int               fact_count;
        outcome_t         pending_outcomes [$];
        int               func_hits [4];
        int               results_checked;
        int               derived_checked;
        int               saturated_checked;
        int               mismatches;

        function new();
            rule_count = 0;
            fact_count = 0;
            results_checked = 0;
            derived_checked = 0;
            saturated_checked = 0;
            mismatches = 0;
            foreach (func_hits[i]) func_hits[i] = 0;
        endfunction

        function bit is_fact(fcc_pkg::symbol_t s);
            for (int i = 0; i < fact_count; i++)
                if (fact_list[i] == s)
                    return 1'b1;
            return 1'b0;
        endfunction

        function void push_outcome(fcc_pkg::kind_t k, fcc_pkg::symbol_t s, bit sat, bit lst);
            outcome_t o;
            o.kind = k;
            o.symbol = s;
            o.saturated = sat;
            o.last = lst;
            pending_outcomes.push_back(o);
        endfunction

        function void note_item(fcc_pkg::func_t f, fcc_pkg::symbol_t a, fcc_pkg::symbol_t b);
            bit added;
            bit sat;
            int r;
            func_hits[f]++;
            case (f)
                fcc_pkg::FUNC_ADD_RULE:
                begin
                    if (rule_count < fcc_pkg::RULE_SLOTS)
                    begin
                        rule_premise[rule_count] = a;
                        rule_conclusion[rule_count] = b;
                        rule_count++;
                        push_outcome(fcc_pkg::KIND_ACCEPTED, '0, 1'b0, 1'b1);
                    end
                    else
                    begin
                        push_outcome(fcc_pkg::KIND_IGNORED, '0, 1'b0, 1'b1);
                    end
                end
                fcc_pkg::FUNC_ADD_FACT:
                begin
                    if (is_fact(a))
                    begin
                        push_outcome(fcc_pkg::KIND_IGNORED, '0, 1'b0, 1'b1);
                    end
                    else if (fact_count >= fcc_pkg::FACT_SLOTS)
                    begin
                        push_outcome(fcc_pkg::KIND_IGNORED, '0, 1'b1, 1'b1);
                    end
                    else
                    begin
                        fact_list[fact_count] = a;
                        fact_count++;
                        push_outcome(fcc_pkg::KIND_ACCEPTED, '0, 1'b0, 1'b1);
                    end
                end
                fcc_pkg::FUNC_CLEAR:
                begin
                    fact_count = 0;
                    push_outcome(fcc_pkg::KIND_ACCEPTED, '0, 1'b0, 1'b1);
                end
                default:
                begin
                    // Sweep the rules until a whole pass adds nothing or the list overflows.
                    sat = 1'b0;
                    do
                    begin
                        added = 1'b0;
                        for (r = 0; r < rule_count; r++)
                        begin
                            if (!is_fact(rule_premise[r]) || is_fact(rule_conclusion[r]))
                                continue;
                            if (fact_count >= fcc_pkg::FACT_SLOTS)
                            begin
                                sat = 1'b1;
                                break;
                            end
                            fact_list[fact_count] = rule_conclusion[r];
                            fact_count++;
                            push_outcome(fcc_pkg::KIND_DERIVED, rule_conclusion[r], 1'b0, 1'b0);
                            added = 1'b1;
                        end
                    end
                    while (added && !sat);
                    push_outcome(fcc_pkg::KIND_DONE, '0, sat, 1'b1);
                end
            endcase
        endfunction

        function void check_outcome(logic [1:0] k, fcc_pkg::symbol_t s, logic sat, logic lst);
            outcome_t want;
            results_checked++;
            if (pending_outcomes.size() == 0)
            begin
                $error("unexpected result: kind %0d symbol %0d saturated %0d last %0d",
                       k, s, sat, lst);
                mismatches++;
                return;
            end
            want = pending_outcomes.pop_front();
            if (want.kind == fcc_pkg::KIND_DERIVED)
                derived_checked++;
            if (want.saturated)
                saturated_checked++;
            if (k !== want.kind)
            begin
                $error("kind mismatch: expected %0d, actual %0d", want.kind, k);
                mismatches++;
            end
            if (s !== want.symbol)
            begin
                $error("symbol mismatch: expected %0d, actual %0d", want.symbol, s);
                mismatches++;
            end
            if (sat !== want.saturated)
            begin
                $error("saturated mismatch: expected %0d, actual %0d", want.saturated, sat);
                mismatches++;
            end
            if (lst !== want.last)
            begin
                $error("last mismatch: expected %0d, actual %0d", want.last, lst);
                mismatches++;
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    fcc_pkg::func_t   func;
    fcc_pkg::symbol_t symbol_a;
    fcc_pkg::symbol_t symbol_b;
    logic             result_valid;
    logic             result_ready;
    logic [1:0]       kind;
    fcc_pkg::symbol_t symbol;
    logic             saturated;
    logic             last;

    closure_scoreboard board;
    int  items_sent;
    int  cycle_count;
    bit  send_calm;
    bit  hold_long;

    forward_chaining_closure_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .func         (func),
        .symbol_a     (symbol_a),
        .symbol_b     (symbol_b),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .symbol       (symbol),
        .saturated    (saturated),
        .last         (last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            board.check_outcome(kind, symbol, saturated, last);
    end

    // Mostly no idle, some short gaps, a few long ones.
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Small symbol pool so that rules chain into each other, plus the top two codes.
    function automatic fcc_pkg::symbol_t pool_symbol();
        int v;
        v = $urandom_range(0, 11);
        return (v > 9) ? fcc_pkg::symbol_t'(244 + v) : fcc_pkg::symbol_t'(v);
    endfunction

    task automatic send_item(fcc_pkg::func_t f, fcc_pkg::symbol_t a, fcc_pkg::symbol_t b);
        int gap;
        item_valid <= 1'b1;
        func <= f;
        symbol_a <= a;
        symbol_b <= b;
        do @(posedge clk); while (!item_ready);
        board.note_item(f, a, b);
        items_sent++;
        @(negedge clk);
        gap = send_calm ? 0 : idle_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic build_sequence();
        int n;
        n = $urandom_range(2, 5);
        repeat (n) send_item(fcc_pkg::FUNC_ADD_RULE, pool_symbol(), pool_symbol());
        if ($urandom_range(0, 1))
            send_item(fcc_pkg::FUNC_CLEAR, fcc_pkg::symbol_t'($urandom),
                      fcc_pkg::symbol_t'($urandom));
        n = $urandom_range(1, 4);
        repeat (n) send_item(fcc_pkg::FUNC_ADD_FACT, pool_symbol(), fcc_pkg::symbol_t'($urandom));
        send_item(fcc_pkg::FUNC_RUN, fcc_pkg::symbol_t'($urandom), fcc_pkg::symbol_t'($urandom));
    endtask

    // Loads the fact list close to or up to capacity, seeded with one live premise,
    // then runs so that derivations can overflow the list.
    task automatic fill_sequence(int target);
        send_item(fcc_pkg::FUNC_CLEAR, fcc_pkg::symbol_t'($urandom),
                  fcc_pkg::symbol_t'($urandom));
        if (board.rule_count > 0)
            send_item(fcc_pkg::FUNC_ADD_FACT,
                      board.rule_premise[$urandom_range(0, board.rule_count - 1)],
                      fcc_pkg::symbol_t'($urandom));
        while (board.fact_count < target)
            send_item(fcc_pkg::FUNC_ADD_FACT, fcc_pkg::symbol_t'($urandom_range(16, 253)),
                      fcc_pkg::symbol_t'($urandom));
        if (target == fcc_pkg::FACT_SLOTS)
        begin
            send_item(fcc_pkg::FUNC_ADD_FACT, board.fact_list[0], fcc_pkg::symbol_t'($urandom));
            send_item(fcc_pkg::FUNC_ADD_FACT, fcc_pkg::symbol_t'($urandom_range(16, 253)),
                      fcc_pkg::symbol_t'($urandom));
        end
        send_item(fcc_pkg::FUNC_RUN, fcc_pkg::symbol_t'($urandom), fcc_pkg::symbol_t'($urandom));
    endtask

    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles with %0d results outstanding.",
                 cycle_count, board.pending_outcomes.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : result_sink
        int stall;
        int calm_left;
        bit calm;
        stall = 0;
        calm_left = 0;
        calm = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (calm_left == 0)
            begin
                calm = ($urandom_range(0, 2) == 0);
                calm_left = $urandom_range(40, 200);
            end
            calm_left--;
            if (hold_long)
            begin
                // Long back-pressure so the output register fills and item_ready drops.
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_long = 1'b0;
            end
            else if (stall > 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
            begin
                result_ready <= 1'b1;
                if (!calm)
                    stall = idle_gap();
            end
        end
    end

    initial
    begin : stimulus
        int seq;
        int r;
        board = new();
        clk = 1'b0;
        rst_n = 1'b0;
        item_valid = 1'b0;
        func = fcc_pkg::FUNC_ADD_RULE;
        symbol_a = '0;
        symbol_b = '0;
        result_ready = 1'b0;
        items_sent = 0;
        send_calm = 1'b0;
        hold_long = 1'b0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty run, field extremes, duplicates, single- and multi-pass closure.
        send_item(fcc_pkg::FUNC_RUN, 8'h00, 8'hFF);
        send_item(fcc_pkg::FUNC_ADD_RULE, 8'h00, 8'hFF);
        send_item(fcc_pkg::FUNC_ADD_RULE, 8'hFF, 8'h80);
        send_item(fcc_pkg::FUNC_ADD_RULE, 8'h80, 8'h01);
        send_item(fcc_pkg::FUNC_ADD_RULE, 8'h55, 8'hAA);
        send_item(fcc_pkg::FUNC_ADD_RULE, 8'hAA, 8'h55);
        send_item(fcc_pkg::FUNC_ADD_FACT, 8'h00, 8'hFF);
        send_item(fcc_pkg::FUNC_ADD_FACT, 8'h00, 8'h00);
        send_item(fcc_pkg::FUNC_ADD_FACT, 8'h7F, 8'h00);
        send_item(fcc_pkg::FUNC_RUN, 8'hFF, 8'hFF);
        send_item(fcc_pkg::FUNC_RUN, 8'h00, 8'h00);
        send_item(fcc_pkg::FUNC_CLEAR, 8'hFF, 8'hFF);
        send_item(fcc_pkg::FUNC_RUN, 8'h00, 8'h00);
        // Rules listed against the chain order, so each pass derives one more fact.
        send_item(fcc_pkg::FUNC_ADD_RULE, 8'h12, 8'h13);
        send_item(fcc_pkg::FUNC_ADD_RULE, 8'h11, 8'h12);
        send_item(fcc_pkg::FUNC_ADD_RULE, 8'h10, 8'h11);
        send_item(fcc_pkg::FUNC_ADD_FACT, 8'h10, 8'h00);
        send_item(fcc_pkg::FUNC_RUN, 8'h00, 8'h00);
        send_item(fcc_pkg::FUNC_CLEAR, 8'h00, 8'h00);
        send_item(fcc_pkg::FUNC_ADD_FACT, 8'hAA, 8'h55);
        send_item(fcc_pkg::FUNC_RUN, 8'h00, 8'h00);

        seq = 0;
        while (items_sent < ITEM_TARGET)
        begin
            send_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (seq == 1)
            begin
                hold_long = 1'b1;
                build_sequence();
            end
            else if (seq == 3)
                fill_sequence(fcc_pkg::FACT_SLOTS);
            else if (r < 6)
                build_sequence();
            else if (r < 9)
                repeat ($urandom_range(1, 3))
                    send_item(fcc_pkg::func_t'($urandom_range(0, 3)),
                              fcc_pkg::symbol_t'($urandom), fcc_pkg::symbol_t'($urandom));
            else if (items_sent + FILL_ROOM <= ITEM_TARGET)
                fill_sequence($urandom_range(26, 31));
            else
                build_sequence();
            seq++;
        end
        item_valid <= 1'b0;

        while (board.pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d transactions: %0d rule adds, %0d fact adds, %0d runs, %0d clears.",
                 items_sent, board.func_hits[fcc_pkg::FUNC_ADD_RULE],
                 board.func_hits[fcc_pkg::FUNC_ADD_FACT],
                 board.func_hits[fcc_pkg::FUNC_RUN], board.func_hits[fcc_pkg::FUNC_CLEAR]);
        $display("Checked %0d results: %0d derived facts, %0d saturated, %0d mismatches.",
                 board.results_checked, board.derived_checked, board.saturated_checked,
                 board.mismatches);
        if (board.mismatches == 0 && board.pending_outcomes.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
